// ===== rtl/fed_pkg.sv =====
// Shared constants of the feedback echo delay: defaults, register map, field widths.
package fed_pkg;

  // Default sizing handed to the top level.
  localparam int unsigned DelayDepthDef = 131072;
  localparam int unsigned SampleBitsDef = 24;

  // Register fields.
  localparam int unsigned LenBits   = 18;
  localparam int unsigned GainBits  = 16;
  localparam int unsigned BlendBits = 17;

  // Register port.
  localparam int unsigned AddrBits = 4;
  localparam int unsigned DataBits = 32;
  localparam int unsigned IdxBits  = 2;

  // Register indexes (byte address is 4 * index).
  localparam logic [IdxBits-1:0] RegDelayLen = 2'd0;
  localparam logic [IdxBits-1:0] RegFbGain   = 2'd1;
  localparam logic [IdxBits-1:0] RegBlend    = 2'd2;

  // Reset values.
  localparam logic [LenBits-1:0]   DelayLenRst = 18'd24000;
  localparam logic [GainBits-1:0]  FbGainRst   = 16'd32768;
  localparam logic [BlendBits-1:0] BlendRst    = 17'd32768;

  // Q1.16 constants.
  localparam logic [BlendBits-1:0] UnityQ16 = 17'h10000;
  localparam logic [BlendBits-1:0] HalfQ16  = 17'h08000;

endpackage

// ===== rtl/feedback_echo_delay.sv =====
// Feedback echo delay: comb filter over a circular delay memory with dry/wet blend.
//
//  channel   direction  handshake                 payload
//  -------   ---------  ------------------------  -------------------------
//  input     in         in_valid_i / in_stall_o   sample_in_i  (signed)
//  output    out        out_valid_o / out_stall_i sample_out_o (signed)
//  config    in         APB psel/penable/pwrite   paddr, pwdata, prdata
//
// Each word goes through these steps from acceptance to its result entering the
// output register: memory read on the accepting edge, then feedback multiply,
// dry/wet multiplies plus write-back, then rounding and saturation. The input
// reopens on the cycle after the result is loaded, so a new word is not taken
// before the last is through, and a stalled output delays that load. The
// single-port delay memory and its read-modify-write keep one word in flight.
// A result waiting in the output register does not block the next word until
// that word's own result is ready to be loaded.
// Reset needs no clearing pass: a fill count marks which entries have been
// written (the ring only ever writes a growing prefix), unwritten ones read as
// zero. Config is expected to be written only while the block is idle.
module feedback_echo_delay #(
  parameter int unsigned DELAY_DEPTH = fed_pkg::DelayDepthDef,
  parameter int unsigned SAMPLE_BITS = fed_pkg::SampleBitsDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // input channel
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0]    sample_in_i,
  // output channel
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [SAMPLE_BITS-1:0]    sample_out_o,
  // config port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [fed_pkg::AddrBits-1:0]     paddr,
  input  logic [fed_pkg::DataBits-1:0]     pwdata,
  output logic [fed_pkg::DataBits-1:0]     prdata,
  output logic                             pready
);

  localparam int unsigned SB   = SAMPLE_BITS;
  localparam int unsigned AW   = $clog2(DELAY_DEPTH);
  localparam int unsigned CW   = (AW + 1 > fed_pkg::LenBits) ? AW + 1 : fed_pkg::LenBits;
  localparam int unsigned GW   = fed_pkg::GainBits;
  localparam int unsigned BW   = fed_pkg::BlendBits;
  // feedback product: signed sample times unsigned gain
  localparam int unsigned PFW  = SB + GW + 1;
  // dry / wet products and their sum
  localparam int unsigned MPW  = SB + BW + 1;
  localparam int unsigned MSW  = MPW + 1;
  // sum after the Q1.16 shift
  localparam int unsigned MXW  = MSW - 16;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StFb   = 2'd1;
  localparam logic [1:0] StMix  = 2'd2;
  localparam logic [1:0] StOut  = 2'd3;

  localparam logic signed [SB-1:0]  SatMax  = {1'b0, {(SB-1){1'b1}}};
  localparam logic signed [SB-1:0]  SatMin  = {1'b1, {(SB-1){1'b0}}};
  localparam logic signed [PFW-1:0] RndFb   = {{(PFW-16){1'b0}}, 16'h8000};
  localparam logic signed [MSW-1:0] RndMix  = {{(MSW-16){1'b0}}, 16'h8000};
  localparam logic [CW-1:0]         DepthCw = CW'(DELAY_DEPTH);

  // ---------------------------------------------------------------------------
  // Config registers
  // ---------------------------------------------------------------------------
  logic [fed_pkg::LenBits-1:0] delay_len_q;
  logic [GW-1:0]               fb_gain_q;
  logic [BW-1:0]               blend_q;
  logic [fed_pkg::IdxBits-1:0] reg_idx;
  logic                        reg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign reg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_len_q <= fed_pkg::DelayLenRst;
      fb_gain_q   <= fed_pkg::FbGainRst;
      blend_q     <= fed_pkg::BlendRst;
    end else if (reg_wr) begin
      unique case (reg_idx)
        fed_pkg::RegDelayLen: delay_len_q <= pwdata[fed_pkg::LenBits-1:0];
        fed_pkg::RegFbGain:   fb_gain_q   <= pwdata[GW-1:0];
        fed_pkg::RegBlend:    blend_q     <= pwdata[BW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      fed_pkg::RegDelayLen: prdata = fed_pkg::DataBits'(delay_len_q);
      fed_pkg::RegFbGain:   prdata = fed_pkg::DataBits'(fb_gain_q);
      fed_pkg::RegBlend:    prdata = fed_pkg::DataBits'(blend_q);
      default:              prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  logic [1:0] state_q, state_d;
  logic       in_acc;
  logic       out_free;

  assign in_stall_o = (state_q != StIdle);
  assign in_acc     = in_valid_i & ~in_stall_o;
  // output register can take a new word this cycle
  assign out_free   = ~out_valid_o | ~out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (in_acc) state_d = StFb;
      StFb:    state_d = StMix;
      StMix:   state_d = StOut;
      StOut:   if (out_free) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StIdle;
    else         state_q <= state_d;
  end

  // ---------------------------------------------------------------------------
  // Delay memory and ring position
  // ---------------------------------------------------------------------------
  logic signed [SB-1:0] mem_q [DELAY_DEPTH];
  logic signed [SB-1:0] rd_q;
  logic signed [SB-1:0] wr_data;
  logic                 wr_en;
  logic [AW-1:0]        pos_q, pos_d;
  logic [AW:0]          fill_q;
  logic                 hit_q;

  assign wr_en = (state_q == StMix);

  always_ff @(posedge clk_i) begin
    if (wr_en)  mem_q[pos_q] <= wr_data;
    if (in_acc) rd_q <= mem_q[pos_q];
  end

  // wrap against the clamped length; a shortened length still wraps cleanly
  logic [CW-1:0] len_cw, limit, pos_inc;
  always_comb begin
    len_cw  = CW'(delay_len_q);
    limit   = (len_cw > DepthCw) ? DepthCw : len_cw;
    pos_inc = CW'(pos_q) + CW'(1);
    pos_d   = (pos_inc >= limit) ? '0 : pos_inc[AW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      fill_q <= '0;
    end else if (wr_en) begin
      pos_q <= pos_d;
      if ({1'b0, pos_q} == fill_q) fill_q <= fill_q + {{AW{1'b0}}, 1'b1};
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath
  // ---------------------------------------------------------------------------
  logic signed [SB-1:0]  x_q;
  logic signed [SB-1:0]  stored;
  logic signed [PFW-1:0] fbp_q;
  logic [BW-1:0]         dry_q, wet_q;
  logic [BW-1:0]         b_clamp, one_minus_b, dry_half, wet_half;
  logic signed [SB-1:0]  fb;
  logic signed [SB:0]    new_sum;
  logic signed [MPW-1:0] dxp_q, wfp_q;
  logic signed [MSW-1:0] mix_sum;
  logic signed [MXW-1:0] mix;
  logic signed [SB-1:0]  mix_sat;
  logic signed [SB-1:0]  out_q;
  logic                  out_valid_q;

  assign stored = hit_q ? rd_q : '0;

  // dry = min(1 - b, 1/2) * 2, wet = min(b, 1/2) * 2
  always_comb begin
    b_clamp     = (blend_q > fed_pkg::UnityQ16) ? fed_pkg::UnityQ16 : blend_q;
    one_minus_b = fed_pkg::UnityQ16 - b_clamp;
    dry_half    = (one_minus_b < fed_pkg::HalfQ16) ? one_minus_b : fed_pkg::HalfQ16;
    wet_half    = (b_clamp < fed_pkg::HalfQ16) ? b_clamp : fed_pkg::HalfQ16;
  end

  // arithmetic shift gives floor, so the part-select above bit 16 is the feedback
  assign fb      = fbp_q[16 +: SB];
  assign new_sum = {x_q[SB-1], x_q} + {fb[SB-1], fb};

  always_comb begin
    if (new_sum[SB] == new_sum[SB-1]) wr_data = new_sum[SB-1:0];
    else                              wr_data = new_sum[SB] ? SatMin : SatMax;
  end

  assign mix_sum = MSW'(dxp_q) + MSW'(wfp_q) + RndMix;
  assign mix     = mix_sum[MSW-1:16];

  always_comb begin
    if ((&mix[MXW-1:SB-1]) | ~(|mix[MXW-1:SB-1])) mix_sat = mix[SB-1:0];
    else mix_sat = mix[MXW-1] ? SatMin : SatMax;
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      x_q   <= sample_in_i;
      hit_q <= ({1'b0, pos_q} < fill_q);
    end
    if (state_q == StFb) begin
      fbp_q <= PFW'(stored * $signed({1'b0, fb_gain_q})) + RndFb;
      dry_q <= {dry_half[BW-2:0], 1'b0};
      wet_q <= {wet_half[BW-2:0], 1'b0};
    end
    if (state_q == StMix) begin
      dxp_q <= MPW'(x_q * $signed({1'b0, dry_q}));
      wfp_q <= MPW'(fb * $signed({1'b0, wet_q}));
    end
    if ((state_q == StOut) && out_free) out_q <= mix_sat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == StOut) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_q;

endmodule
